// File: rtl/core/sbcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_pkg
// Types, constants and helper functions shared by the servo bus framer.
// ----------------------------------------------------------------------------
package sbcf_pkg;

    // Longest frame: brace, 15 ASCII characters, brace.
    localparam int NUM_CELLS = 17;
    localparam int LEN_W     = $clog2(NUM_CELLS + 1);

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] OP_MOVE    = 8'h01;
    localparam logic [7:0] OP_TORQUE  = 8'h1E;
    localparam logic [7:0] LEN_MOVE   = 8'h07;
    localparam logic [7:0] LEN_TORQUE = 8'h04;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [15:0] ASCII_MAX = 16'd9999;

    localparam logic [LEN_W-1:0] FRAME_LEN_MOVE   = LEN_W'(10);
    localparam logic [LEN_W-1:0] FRAME_LEN_TORQUE = LEN_W'(7);
    localparam logic [LEN_W-1:0] FRAME_LEN_ASCII  = LEN_W'(15);

    typedef enum logic [1:0] {
        CMD_MOVE   = 2'd0,
        CMD_TORQUE = 2'd1,
        CMD_ASCII  = 2'd2
    } t_cmd;

    // One byte position of the output shift chain.
    typedef struct packed {
        logic       vld;
        logic       last;
        logic [7:0] data;
    } t_cell;

    // A complete frame, byte 0 goes out first.
    typedef struct packed {
        logic [LEN_W-1:0]           len;
        logic [NUM_CELLS-1:0][7:0]  data;
    } t_frame;

    // Command context as it moves through the digit pipeline.
    typedef struct packed {
        t_cmd            cmd;
        logic [7:0]      id;
        logic [15:0]     val;
        logic [15:0]     tim;
        logic            ten;
        logic            go;
        logic            gc;
        logic [7:0]      chk;
        logic [13:0]     id_r;
        logic [13:0]     val_r;
        logic [13:0]     tim_r;
        logic [2:0][3:0] id_d;
        logic [3:0][3:0] val_d;
        logic [3:0][3:0] tim_d;
    } t_ctx;

    typedef struct packed {
        logic [3:0]  d;
        logic [13:0] r;
    } t_dig;

    // Leading decimal digit of v for the given place, with the remainder.
    // Expects v below ten times the place.
    function automatic t_dig dec_digit(input logic [13:0] v, input logic [13:0] unit);
        t_dig        res;
        logic [13:0] th;
        res.d = 4'd0;
        res.r = v;
        for (int k = 1; k <= 9; k++) begin
            th = 14'(k * unit);
            if (v >= th) begin
                res.d = 4'(k);
                res.r = v - th;
            end
        end
        return res;
    endfunction

    function automatic logic [7:0] to_ascii(input logic [3:0] d);
        return CH_ZERO | {4'b0000, d};
    endfunction

endpackage

// File: rtl/core/sbcf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_cell
// One byte position of the output chain: loads a frame byte or takes the
// byte of its upstream neighbor when the chain shifts.
// ----------------------------------------------------------------------------
module sbcf_cell
    import sbcf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  logic  i_shift,
    input  t_cell i_load_cell,
    input  t_cell i_next_cell,
    output t_cell o_cell
);

    logic       r_vld;
    logic       r_last;
    logic [7:0] r_data;
    logic       n_vld;
    logic       n_last;
    logic [7:0] n_data;

    always_comb begin
        n_vld  = r_vld;
        n_last = r_last;
        n_data = r_data;
        priority if (i_load) begin
            n_vld  = i_load_cell.vld;
            n_last = i_load_cell.last;
            n_data = i_load_cell.data;
        end else if (i_shift) begin
            n_vld  = i_next_cell.vld;
            n_last = i_next_cell.last;
            n_data = i_next_cell.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= n_last;
        r_data <= n_data;
    end

    assign o_cell = '{vld: r_vld, last: r_last, data: r_data};

endmodule

// File: rtl/core/sbcf_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_encoder
// Four-stage elastic pipeline: captures a command, works out the checksum and
// the decimal digits over the following stages, and assembles the finished frame.
// ----------------------------------------------------------------------------
module sbcf_encoder
    import sbcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_servo_id,
    input  logic [15:0] i_target_value,
    input  logic [15:0] i_move_time,
    input  logic        i_torque_on,
    input  logic        i_group_open,
    input  logic        i_group_close,
    output logic        o_frame_valid,
    output t_frame      o_frame,
    input  logic        i_frame_take
);

    logic   r_s1_vld, r_s2_vld, r_s3_vld, r_frame_vld;
    t_ctx   r_s1, r_s2, r_s3;
    t_frame r_frame;
    t_ctx   n_s1, n_s2, n_s3;
    t_frame n_frame;
    logic   w_rdy2, w_rdy3, w_rdy4;
    logic   w_cmd_ok;

    assign w_rdy4     = !r_frame_vld || i_frame_take;
    assign w_rdy3     = !r_s3_vld || w_rdy4;
    assign w_rdy2     = !r_s2_vld || w_rdy3;
    assign o_in_ready = !r_s1_vld || w_rdy2;

    // The unused selector code is taken and dropped without a frame.
    assign w_cmd_ok = (i_cmd == CMD_MOVE) || (i_cmd == CMD_TORQUE) || (i_cmd == CMD_ASCII);

    always_comb begin
        n_s1     = '0;
        n_s1.cmd = t_cmd'(i_cmd);
        n_s1.id  = i_servo_id;
        n_s1.val = i_target_value;
        n_s1.tim = i_move_time;
        n_s1.ten = i_torque_on;
        n_s1.go  = i_group_open;
        n_s1.gc  = i_group_close;
    end

    // Stage 2: checksum, saturation, thousands and id hundreds.
    always_comb begin
        logic [7:0]  sum;
        logic [13:0] val_sat;
        logic [13:0] tim_sat;
        t_dig        dv, dt, di;
        n_s2 = r_s1;
        if (r_s1.cmd == CMD_TORQUE) begin
            sum = r_s1.id + LEN_TORQUE + OP_TORQUE + {7'd0, r_s1.ten};
        end else begin
            sum = r_s1.id + LEN_MOVE + OP_MOVE + r_s1.val[7:0] + r_s1.val[15:8]
                + r_s1.tim[7:0] + r_s1.tim[15:8];
        end
        n_s2.chk = ~sum;
        val_sat = (r_s1.val > ASCII_MAX) ? ASCII_MAX[13:0] : r_s1.val[13:0];
        tim_sat = (r_s1.tim > ASCII_MAX) ? ASCII_MAX[13:0] : r_s1.tim[13:0];
        dv = dec_digit(val_sat, 14'd1000);
        dt = dec_digit(tim_sat, 14'd1000);
        di = dec_digit({6'd0, r_s1.id}, 14'd100);
        n_s2.val_d[3] = dv.d;
        n_s2.val_r    = dv.r;
        n_s2.tim_d[3] = dt.d;
        n_s2.tim_r    = dt.r;
        n_s2.id_d[2]  = di.d;
        n_s2.id_r     = di.r;
    end

    // Stage 3: hundreds, and the last two id digits.
    always_comb begin
        t_dig dv, dt, di;
        n_s3 = r_s2;
        dv = dec_digit(r_s2.val_r, 14'd100);
        dt = dec_digit(r_s2.tim_r, 14'd100);
        di = dec_digit(r_s2.id_r, 14'd10);
        n_s3.val_d[2] = dv.d;
        n_s3.val_r    = dv.r;
        n_s3.tim_d[2] = dt.d;
        n_s3.tim_r    = dt.r;
        n_s3.id_d[1]  = di.d;
        n_s3.id_d[0]  = di.r[3:0];
    end

    // Stage 4: tens and ones, then the frame bytes.
    always_comb begin
        t_dig                       dv, dt;
        logic [3:0][3:0]            vd, td;
        logic [NUM_CELLS-2:0][7:0]  seq;
        dv = dec_digit(r_s3.val_r, 14'd10);
        dt = dec_digit(r_s3.tim_r, 14'd10);
        vd = {r_s3.val_d[3], r_s3.val_d[2], dv.d, dv.r[3:0]};
        td = {r_s3.tim_d[3], r_s3.tim_d[2], dt.d, dt.r[3:0]};

        seq     = '0;
        seq[0]  = CH_HASH;
        seq[1]  = to_ascii(r_s3.id_d[2]);
        seq[2]  = to_ascii(r_s3.id_d[1]);
        seq[3]  = to_ascii(r_s3.id_d[0]);
        seq[4]  = CH_P;
        seq[5]  = to_ascii(vd[3]);
        seq[6]  = to_ascii(vd[2]);
        seq[7]  = to_ascii(vd[1]);
        seq[8]  = to_ascii(vd[0]);
        seq[9]  = CH_T;
        seq[10] = to_ascii(td[3]);
        seq[11] = to_ascii(td[2]);
        seq[12] = to_ascii(td[1]);
        seq[13] = to_ascii(td[0]);
        seq[14] = CH_BANG;
        seq[15] = r_s3.gc ? CH_RBRACE : 8'h00;

        n_frame = '0;
        unique case (r_s3.cmd)
            CMD_MOVE: begin
                n_frame.len     = FRAME_LEN_MOVE;
                n_frame.data[0] = HDR_BYTE;
                n_frame.data[1] = HDR_BYTE;
                n_frame.data[2] = r_s3.id;
                n_frame.data[3] = LEN_MOVE;
                n_frame.data[4] = OP_MOVE;
                n_frame.data[5] = r_s3.val[7:0];
                n_frame.data[6] = r_s3.val[15:8];
                n_frame.data[7] = r_s3.tim[7:0];
                n_frame.data[8] = r_s3.tim[15:8];
                n_frame.data[9] = r_s3.chk;
            end
            CMD_TORQUE: begin
                n_frame.len     = FRAME_LEN_TORQUE;
                n_frame.data[0] = HDR_BYTE;
                n_frame.data[1] = HDR_BYTE;
                n_frame.data[2] = r_s3.id;
                n_frame.data[3] = LEN_TORQUE;
                n_frame.data[4] = OP_TORQUE;
                n_frame.data[5] = {7'd0, r_s3.ten};
                n_frame.data[6] = r_s3.chk;
            end
            CMD_ASCII: begin
                n_frame.len = FRAME_LEN_ASCII + LEN_W'(r_s3.go) + LEN_W'(r_s3.gc);
                if (r_s3.go) begin
                    n_frame.data[0] = CH_LBRACE;
                    for (int k = 1; k < NUM_CELLS; k++) begin
                        n_frame.data[k] = seq[k-1];
                    end
                end else begin
                    for (int k = 0; k < NUM_CELLS - 1; k++) begin
                        n_frame.data[k] = seq[k];
                    end
                end
            end
            default: begin
                n_frame = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
            r_frame_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid && w_cmd_ok;
            end
            if (w_rdy2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (w_rdy3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (w_rdy4) begin
                r_frame_vld <= r_s3_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1 <= n_s1;
        end
        if (w_rdy2 && r_s1_vld) begin
            r_s2 <= n_s2;
        end
        if (w_rdy3 && r_s2_vld) begin
            r_s3 <= n_s3;
        end
        if (w_rdy4 && r_s3_vld) begin
            r_frame <= n_frame;
        end
    end

    assign o_frame_valid = r_frame_vld;
    assign o_frame       = r_frame;

endmodule

// File: rtl/core/servo_bus_command_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_bus_command_framer
// Turns servo commands into bus byte streams: binary move (10 bytes), binary
// torque (7 bytes) or an ASCII move string with optional group braces.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_in_valid / o_in_ready) takes one command word with
// its fields on separate ports. The output channel (o_out_valid /
// i_out_ready) delivers one byte word per transfer, o_last_byte marking the
// final byte of a command. An unused selector code is taken and yields no
// bytes.
// A command passes a four-stage pipeline that forms the checksum and the
// decimal digits, then loads into a row of 17 byte cells that shifts one
// byte toward the output on every transfer. A command of n bytes occupies
// the output for n transfers (7, 10 or 15 to 17); the next frame loads
// while the last byte of the current one goes out, so frames follow
// without a gap and up to four further commands wait in the pipeline
// meanwhile.
// A stalled receiver freezes the cell row and, once it is full, the
// pipeline, which then drops o_in_ready. Reset empties the pipeline and the
// cell row.
// ----------------------------------------------------------------------------
module servo_bus_command_framer
    import sbcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_servo_id,
    input  logic [15:0] i_target_value,
    input  logic [15:0] i_move_time,
    input  logic        i_torque_on,
    input  logic        i_group_open,
    input  logic        i_group_close,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    logic   w_frame_valid;
    t_frame w_frame;
    logic   w_load;
    logic   w_shift;
    t_cell  w_cell [NUM_CELLS];

    sbcf_encoder u_encoder (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_servo_id     (i_servo_id),
        .i_target_value (i_target_value),
        .i_move_time    (i_move_time),
        .i_torque_on    (i_torque_on),
        .i_group_open   (i_group_open),
        .i_group_close  (i_group_close),
        .o_frame_valid  (w_frame_valid),
        .o_frame        (w_frame),
        .i_frame_take   (w_load)
    );

    // A frame always sits at the head of the row, so the row is free once
    // the second cell is empty and the head is empty or leaving.
    assign w_shift = w_cell[0].vld && i_out_ready;
    assign w_load  = w_frame_valid && !w_cell[1].vld && (!w_cell[0].vld || i_out_ready);

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        t_cell w_load_cell;
        t_cell w_next_cell;

        assign w_load_cell.vld  = LEN_W'(g) < w_frame.len;
        assign w_load_cell.last = LEN_W'(g + 1) == w_frame.len;
        assign w_load_cell.data = w_frame.data[g];

        if (g < NUM_CELLS - 1) begin : g_mid
            assign w_next_cell = w_cell[g+1];
        end else begin : g_end
            assign w_next_cell = '0;
        end

        sbcf_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_load),
            .i_shift     (w_shift),
            .i_load_cell (w_load_cell),
            .i_next_cell (w_next_cell),
            .o_cell      (w_cell[g])
        );
    end

    assign o_out_valid = w_cell[0].vld;
    assign o_out_byte  = w_cell[0].data;
    assign o_last_byte = w_cell[0].last;

endmodule

// File: rtl/core/sbcf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcf_checker
// Port-level checks for the servo bus framer: frame starts, frame length,
// reset and output hold under stall.
// ----------------------------------------------------------------------------
module sbcf_checker
    import sbcf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_last_byte
);

    logic             r_first;
    logic [LEN_W-1:0] r_cnt;

    // Tracks the position of the current output word within its frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_cnt   <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_first <= o_last_byte;
            r_cnt   <= o_last_byte ? '0 : r_cnt + LEN_W'(1);
        end
    end

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_first) |->
            (o_out_byte == HDR_BYTE || o_out_byte == CH_LBRACE || o_out_byte == CH_HASH))
        else $error("frame does not open with a header, brace or hash");

    a_frame_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cnt == LEN_W'(NUM_CELLS - 1)) |-> o_last_byte)
        else $error("frame longer than the cell row");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_out_byte) && $stable(o_last_byte)))
        else $error("output word changed while stalled");

endmodule

bind servo_bus_command_framer sbcf_checker u_sbcf_checker (.*);

// File: dv/servo_bus_command_framer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_bus_command_framer_tb
// Self-checking bench for the servo bus framer. Commands are queued by the
// stimulus process and offered by a clocked driver. Every accepted command
// is framed by an in-bench model into its expected byte words, which a
// clocked monitor compares against the output channel in order. The run
// covers directed corner commands, then random traffic under several
// sender and receiver idling mixes, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module servo_bus_command_framer_tb;
    import sbcf_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         PHASE_ITEMS    = 62;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  id;
        logic [15:0] val;
        logic [15:0] tim;
        logic        ten;
        logic        go;
        logic        gc;
    } servo_cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } bus_byte_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_cmd          = '0;
    logic [7:0]  i_servo_id     = '0;
    logic [15:0] i_target_value = '0;
    logic [15:0] i_move_time    = '0;
    logic        i_torque_on    = 1'b0;
    logic        i_group_open   = 1'b0;
    logic        i_group_close  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    servo_cmd_t cmd_queue[$];
    bus_byte_t  bus_expect_q[$];

    int n_errors       = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    bit hold_go        = 1'b0;
    bit hold_taken     = 1'b0;

    servo_bus_command_framer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_servo_id     (i_servo_id),
        .i_target_value (i_target_value),
        .i_move_time    (i_move_time),
        .i_torque_on    (i_torque_on),
        .i_group_open   (i_group_open),
        .i_group_close  (i_group_close),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_last_byte    (o_last_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] dec_char(input int v, input int place);
        return CH_ZERO + 8'((v / place) % 10);
    endfunction

    // Builds the byte stream of one command and queues it as expected words.
    task automatic frame_command(input servo_cmd_t c);
        logic [7:0]  fb[$];
        logic [7:0]  sum;
        logic [15:0] v;
        logic [15:0] t;
        fb = {};
        case (c.cmd)
            CMD_MOVE, CMD_TORQUE: begin
                fb.push_back(HDR_BYTE);
                fb.push_back(HDR_BYTE);
                fb.push_back(c.id);
                if (c.cmd == CMD_MOVE) begin
                    fb.push_back(LEN_MOVE);
                    fb.push_back(OP_MOVE);
                    fb.push_back(c.val[7:0]);
                    fb.push_back(c.val[15:8]);
                    fb.push_back(c.tim[7:0]);
                    fb.push_back(c.tim[15:8]);
                end else begin
                    fb.push_back(LEN_TORQUE);
                    fb.push_back(OP_TORQUE);
                    fb.push_back({7'b0, c.ten});
                end
                sum = '0;
                for (int k = 2; k < fb.size(); k++) sum += fb[k];
                fb.push_back(~sum);
            end
            CMD_ASCII: begin
                v = (c.val > ASCII_MAX) ? ASCII_MAX : c.val;
                t = (c.tim > ASCII_MAX) ? ASCII_MAX : c.tim;
                if (c.go) fb.push_back(CH_LBRACE);
                fb.push_back(CH_HASH);
                for (int p = 100; p >= 1; p /= 10) fb.push_back(dec_char(c.id, p));
                fb.push_back(CH_P);
                for (int p = 1000; p >= 1; p /= 10) fb.push_back(dec_char(v, p));
                fb.push_back(CH_T);
                for (int p = 1000; p >= 1; p /= 10) fb.push_back(dec_char(t, p));
                fb.push_back(CH_BANG);
                if (c.gc) fb.push_back(CH_RBRACE);
            end
            default: begin
                // The unused selector is taken silently.
            end
        endcase
        for (int k = 0; k < fb.size(); k++)
            bus_expect_q.push_back('{data: fb[k], last: (k == fb.size() - 1)});
    endtask

    // Mostly values near the corners and the ASCII saturation point.
    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(10010, 9989));
            3:       return 16'($urandom_range(9999));
            4:       return 16'($urandom_range(99));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic servo_cmd_t random_command();
        servo_cmd_t c;
        int         r;
        r = $urandom_range(99);
        if (r < 30)      c.cmd = CMD_MOVE;
        else if (r < 55) c.cmd = CMD_TORQUE;
        else if (r < 95) c.cmd = CMD_ASCII;
        else             c.cmd = CMD_UNUSED;
        c.id  = 8'($urandom);
        c.val = pick_word();
        c.tim = pick_word();
        c.ten = 1'($urandom);
        c.go  = 1'($urandom);
        c.gc  = 1'($urandom);
        return c;
    endfunction

    // Command driver: predicts on acceptance, then offers the next word.
    always @(posedge i_clk) begin : drive_commands
        servo_cmd_t nx;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                frame_command('{i_cmd, i_servo_id, i_target_value, i_move_time,
                                i_torque_on, i_group_open, i_group_close});
            if (!i_in_valid || o_in_ready) begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nx = cmd_queue.pop_front();
                    i_cmd          <= nx.cmd;
                    i_servo_id     <= nx.id;
                    i_target_value <= nx.val;
                    i_move_time    <= nx.tim;
                    i_torque_on    <= nx.ten;
                    i_group_open   <= nx.go;
                    i_group_close  <= nx.gc;
                    i_in_valid     <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor and receiver ready generation.
    always @(posedge i_clk) begin : check_bytes
        bus_byte_t want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (bus_expect_q.size() == 0) begin
                    $error("unexpected word: out_byte %h last_byte %b",
                           o_out_byte, o_last_byte);
                    n_errors++;
                end else begin
                    want = bus_expect_q.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %h, actual %h", want.data, o_out_byte);
                        n_errors++;
                    end
                    if (o_last_byte !== want.last) begin
                        $error("last_byte: expected %b, actual %b", want.last, o_last_byte);
                        n_errors++;
                    end
                end
            end
            if (hold_go && !hold_taken) begin
                hold_taken  <= 1'b1;
                hold_left   <= HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_random(input int count);
        servo_cmd_t c;
        int         taken;
        taken = 0;
        while (taken < count) begin
            c = random_command();
            cmd_queue.push_back(c);
            if (c.cmd != CMD_UNUSED) taken++;
        end
    endtask

    task automatic wait_sent();
        while (cmd_queue.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners: field extremes, every packet kind, ASCII
        // saturation, brace combinations, braces on binary packets, and
        // the unused selector.
        cmd_queue.push_back('{CMD_MOVE,   8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0});
        cmd_queue.push_back('{CMD_MOVE,   8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1});
        cmd_queue.push_back('{CMD_MOVE,   8'hA5, 16'h1234, 16'h8001, 1'b0, 1'b1, 1'b0});
        cmd_queue.push_back('{CMD_TORQUE, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0});
        cmd_queue.push_back('{CMD_TORQUE, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0});
        cmd_queue.push_back('{CMD_TORQUE, 8'h3C, 16'h5555, 16'hAAAA, 1'b1, 1'b1, 1'b1});
        cmd_queue.push_back('{CMD_TORQUE, 8'hE1, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b1});
        cmd_queue.push_back('{CMD_ASCII,  8'h00, 16'd0,    16'd0,    1'b0, 1'b0, 1'b0});
        cmd_queue.push_back('{CMD_ASCII,  8'hFF, 16'd9999, 16'd9999, 1'b1, 1'b0, 1'b0});
        cmd_queue.push_back('{CMD_ASCII,  8'd7,  16'd10000, 16'hFFFF, 1'b0, 1'b0, 1'b0});
        cmd_queue.push_back('{CMD_ASCII,  8'd99, 16'hFFFF, 16'd10000, 1'b0, 1'b1, 1'b0});
        cmd_queue.push_back('{CMD_ASCII,  8'd100, 16'd9998, 16'd1,   1'b0, 1'b0, 1'b0});
        cmd_queue.push_back('{CMD_ASCII,  8'd42, 16'd1500, 16'd250,  1'b1, 1'b0, 1'b1});
        cmd_queue.push_back('{CMD_ASCII,  8'd9,  16'd1000, 16'd9,    1'b0, 1'b1, 1'b1});
        cmd_queue.push_back('{CMD_ASCII,  8'd200, 16'd10001, 16'd0,  1'b0, 1'b1, 1'b1});
        cmd_queue.push_back('{CMD_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1});
        cmd_queue.push_back('{CMD_MOVE,   8'h5A, 16'h00FF, 16'hFF00, 1'b1, 1'b0, 1'b1});
        cmd_queue.push_back('{CMD_UNUSED, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0});
        cmd_queue.push_back('{CMD_ASCII,  8'd1,  16'd1,    16'd1000, 1'b0, 1'b1, 1'b1});
        wait_sent();

        // No idling, with one long receiver hold-off so the pipeline backs up.
        queue_random(PHASE_ITEMS);
        hold_go = 1'b1;
        wait_sent();

        send_idle_pct  = 53;
        recv_stall_pct = 0;
        queue_random(PHASE_ITEMS);
        wait_sent();

        send_idle_pct  = 0;
        recv_stall_pct = 53;
        queue_random(PHASE_ITEMS);
        wait_sent();

        send_idle_pct  = 23;
        recv_stall_pct = 23;
        queue_random(PHASE_ITEMS);
        wait_sent();

        while (i_in_valid) @(negedge i_clk);
        while (bus_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (n_errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
